// ===== hw/rtl/shpd_pkg.sv =====
package shpd_pkg;

  // Number of payload bytes that carry result fields.
  localparam int unsigned FieldCount = 14;
  localparam int unsigned FieldIdxW  = $clog2(FieldCount);

  // Default packet payload length, at least FieldCount.
  localparam int unsigned PayloadBytesDef = 14;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SYNC_SECOND = 2'd1;

  localparam logic [7:0] SyncFirstRst  = 8'hAA;
  localparam logic [7:0] SyncSecondRst = 8'h55;

  // Byte offsets of the result fields within the payload.
  localparam int unsigned AddrOffs   = 0;
  localparam int unsigned StatusOffs = 8;
  localparam int unsigned TempOffs   = 9;
  localparam int unsigned ResOffs    = 13;

  typedef logic [7:0] byte_t;

endpackage

// ===== hw/rtl/sync_header_packet_deframer.sv =====
// A result appears on the output in the cycle after the last payload word is accepted.
// Throughput: one received word per cycle; the input stalls only while a result waits unread.
// The final payload word reaches the result register directly, bypassing the payload store.
// Reset (asynchronous, active low) returns the block to header hunting with no previous
// word held and restores the sync bytes to AA 55; the payload byte store is not cleared.
module sync_header_packet_deframer #(
  parameter int unsigned PAYLOAD_BYTES = shpd_pkg::PayloadBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          cfg_we_i,
  input  logic [shpd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [shpd_pkg::CfgDataW-1:0] cfg_wdata_i,

  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    rx_byte_i,

  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [63:0]                   device_address_o,
  output logic [7:0]                    sensor_status_o,
  output logic [31:0]                   temperature_word_o,
  output logic [7:0]                    resolution_code_o
);
  import shpd_pkg::*;

  localparam int unsigned CntW = $clog2(PAYLOAD_BYTES);
  localparam logic [CntW-1:0] LastCnt  = CntW'(PAYLOAD_BYTES - 1);
  localparam logic [CntW-1:0] FieldCnt = CntW'(FieldCount);

  logic [7:0]     sync_first_q, sync_second_q;
  logic           collecting_q, collecting_d;
  byte_t          prev_byte_q, prev_byte_d;
  logic           prev_valid_q, prev_valid_d;
  logic [CntW-1:0] count_q, count_d;
  byte_t          field_q [FieldCount];
  byte_t          field_d [FieldCount];
  logic           out_valid_q, out_valid_d;
  logic [63:0]    addr_q;
  logic [7:0]     status_q, res_q;
  logic [31:0]    temp_q;

  logic in_acc;
  logic hdr_match;
  logic pkt_done;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SyncFirstRst;
      sync_second_q <= SyncSecondRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SYNC_FIRST:  sync_first_q  <= cfg_wdata_i;
        CFG_SYNC_SECOND: sync_second_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign hdr_match = prev_valid_q && (prev_byte_q == sync_first_q) &&
                     (rx_byte_i == sync_second_q);
  assign pkt_done  = collecting_q && (count_q == LastCnt);

  // The newest payload word is merged in here so that the final field byte
  // reaches the result register in the same cycle it arrives.
  always_comb begin
    for (int i = 0; i < FieldCount; i++) begin
      field_d[i] = field_q[i];
    end
    if (collecting_q && (count_q < FieldCnt)) begin
      field_d[count_q[FieldIdxW-1:0]] = rx_byte_i;
    end
  end

  always_comb begin
    collecting_d = collecting_q;
    prev_byte_d  = prev_byte_q;
    prev_valid_d = prev_valid_q;
    count_d      = count_q;
    if (in_acc) begin
      if (!collecting_q) begin
        if (hdr_match) begin
          collecting_d = 1'b1;
          count_d      = '0;
          prev_valid_d = 1'b0;
          prev_byte_d  = '0;
        end else begin
          prev_byte_d  = rx_byte_i;
          prev_valid_d = 1'b1;
        end
      end else if (pkt_done) begin
        collecting_d = 1'b0;
        count_d      = '0;
        prev_valid_d = 1'b0;
        prev_byte_d  = '0;
      end else begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_acc && pkt_done) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      prev_byte_q  <= '0;
      prev_valid_q <= 1'b0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      collecting_q <= collecting_d;
      prev_byte_q  <= prev_byte_d;
      prev_valid_q <= prev_valid_d;
      count_q      <= count_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload store and result register.
  always_ff @(posedge clk_i) begin
    if (in_acc && collecting_q) begin
      for (int i = 0; i < FieldCount; i++) begin
        field_q[i] <= field_d[i];
      end
    end
    if (in_acc && pkt_done) begin
      for (int k = 0; k < 8; k++) begin
        addr_q[8*k +: 8] <= field_d[AddrOffs + k];
      end
      status_q <= field_d[StatusOffs];
      for (int k = 0; k < 4; k++) begin
        temp_q[8*k +: 8] <= field_d[TempOffs + k];
      end
      res_q <= field_d[ResOffs];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign device_address_o   = addr_q;
  assign sensor_status_o    = status_q;
  assign temperature_word_o = temp_q;
  assign resolution_code_o  = res_q;

`ifndef NO_ASSERTIONS
  // Collection only ends by completing a packet, which always loads a result.
  a_done_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(collecting_q) |-> out_valid_q)
    else $error("packet ended without a result");

  // The counter is idle at zero while hunting.
  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !collecting_q |-> (count_q == '0))
    else $error("payload counter not cleared while hunting");

  // A word is never taken while a result is stuck at the output.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !in_acc)
    else $error("input accepted while result stalled");

  // The hunt history is dropped whenever a header is found.
  a_prev_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(collecting_q) |-> !prev_valid_q)
    else $error("previous word kept after header");
`endif

endmodule

// ===== test/sync_header_packet_deframer_test.sv =====
module sync_header_packet_deframer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import shpd_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 2'd3;
  localparam int unsigned RandomPhases = 10;
  localparam int unsigned PhaseWords   = 160;

  typedef struct packed {
    logic [63:0] device_address;
    logic [7:0]  sensor_status;
    logic [31:0] temperature_word;
    logic [7:0]  resolution_code;
  } sensor_record_t;

  typedef enum logic {ROW_RX, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CfgIdxW-1:0]   idx;
    byte_t                value;
    logic [4:0]           count;
    bit                   stated;
    sensor_record_t       rec;
  } stim_row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [7:0]          rx_byte_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [63:0]         device_address_o;
  logic [7:0]          sensor_status_o;
  logic [31:0]         temperature_word_o;
  logic [7:0]          resolution_code_o;

  sync_header_packet_deframer dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .rx_byte_i,
    .out_valid_o,
    .out_ready_i,
    .device_address_o,
    .sensor_status_o,
    .temperature_word_o,
    .resolution_code_o
  );

  // Predictor state: a private copy of the sync bytes and of the framing state.
  byte_t       want_first;
  byte_t       want_second;
  bit          in_packet;
  byte_t       last_byte;
  bit          last_held;
  logic [5:0]  taken;
  byte_t       field_store [FieldCount];

  sensor_record_t pending_records [$];
  int unsigned    miss_count = 0;
  int unsigned    words_sent = 0;
  bit             src_gaps   = 1'b0;
  bit             sink_gaps  = 1'b0;
  int unsigned    sink_hold  = 0;
  stim_row_t      directed_rows [10];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #(10_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Advances the predictor by one received word; returns 1 when a packet completes.
  function automatic bit take_rx_byte(input byte_t b, output sensor_record_t rec);
    rec = '0;
    if (!in_packet) begin
      if (last_held && last_byte == want_first && b == want_second) begin
        in_packet = 1'b1;
        taken     = '0;
        last_held = 1'b0;
        last_byte = '0;
      end else begin
        last_byte = b;
        last_held = 1'b1;
      end
      return 1'b0;
    end
    if (taken < FieldCount) field_store[taken[FieldIdxW-1:0]] = b;
    taken = taken + 6'd1;
    if (taken >= PayloadBytesDef) begin
      for (int k = 0; k < 8; k++) rec.device_address[8*k +: 8] = field_store[AddrOffs + k];
      rec.sensor_status = field_store[StatusOffs];
      for (int k = 0; k < 4; k++) rec.temperature_word[8*k +: 8] = field_store[TempOffs + k];
      rec.resolution_code = field_store[ResOffs];
      in_packet = 1'b0;
      taken     = '0;
      last_held = 1'b0;
      last_byte = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Called just after a falling edge; returns just after a falling edge with valid
  // still high, so that a following word can replace the payload without a gap.
  task automatic send_rx(input byte_t b, input bit stated, input sensor_record_t rec);
    sensor_record_t got;
    bit             made;
    int unsigned    gap;
    gap = src_gaps ? idle_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    made = take_rx_byte(b, got);
    if (made) pending_records.push_back(stated ? rec : got);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_records.size() != 0) @(negedge clk_i);
    // A word that completes no packet may still be in flight.
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input byte_t value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_SYNC_FIRST) want_first = value;
    else if (idx == CFG_SYNC_SECOND) want_second = value;
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (sink_hold != 0) begin
      out_ready_i <= 1'b0;
      sink_hold   <= sink_hold - 1;
    end else begin
      out_ready_i <= 1'b1;
      if (sink_gaps) sink_hold <= idle_len();
    end
  end

  always @(posedge clk_i) begin : result_check
    sensor_record_t seen;
    sensor_record_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen = '{device_address_o, sensor_status_o, temperature_word_o, resolution_code_o};
      if (pending_records.size() == 0) begin
        miss_count++;
        if (miss_count <= 10)
          $display("%0t: unexpected record addr=%h status=%h temp=%h res=%h", $realtime,
                   seen.device_address, seen.sensor_status, seen.temperature_word,
                   seen.resolution_code);
      end else begin
        want = pending_records.pop_front();
        if (seen.device_address !== want.device_address ||
            seen.sensor_status !== want.sensor_status ||
            seen.temperature_word !== want.temperature_word ||
            seen.resolution_code !== want.resolution_code) begin
          miss_count++;
          if (miss_count <= 10) begin
            $display("%0t: record mismatch: expected addr=%h status=%h temp=%h res=%h",
                     $realtime, want.device_address, want.sensor_status,
                     want.temperature_word, want.resolution_code);
            $display("  got addr=%h status=%h temp=%h res=%h", seen.device_address,
                     seen.sensor_status, seen.temperature_word, seen.resolution_code);
          end
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned counted;
    int unsigned mode;
    int unsigned r;
    byte_t       v;
    byte_t       pb;

    want_first  = SyncFirstRst;
    want_second = SyncSecondRst;
    in_packet   = 1'b0;
    last_byte   = '0;
    last_held   = 1'b0;
    taken       = '0;
    for (int k = 0; k < FieldCount; k++) field_store[k] = '0;

    // A repeated first sync byte restarts the match; the sync bytes change halfway
    // through a packet; the spare indexes must not alias onto the real registers;
    // equal sync bytes, and a header that appears again inside the payload.
    directed_rows = '{
      '{ROW_RX,  '0,              8'hAA, 5'd2,  1'b0, '0},
      '{ROW_RX,  '0,              8'h55, 5'd1,  1'b0, '0},
      '{ROW_RX,  '0,              8'hFF, 5'd7,  1'b0, '0},
      '{ROW_CFG, CFG_SYNC_FIRST,  8'h00, 5'd1,  1'b0, '0},
      '{ROW_CFG, CFG_SYNC_SECOND, 8'h00, 5'd1,  1'b0, '0},
      '{ROW_CFG, CFG_SPARE_LO,    8'hFF, 5'd1,  1'b0, '0},
      '{ROW_CFG, CFG_SPARE_HI,    8'hFF, 5'd1,  1'b0, '0},
      '{ROW_RX,  '0,              8'hFF, 5'd7,  1'b1,
        '{64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF}},
      '{ROW_RX,  '0,              8'h00, 5'd2,  1'b0, '0},
      '{ROW_RX,  '0,              8'h00, 5'd14, 1'b1, '0}
    };

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        drain();
        cfg_write(directed_rows[i].idx, directed_rows[i].value);
      end else begin
        for (int k = 0; k < directed_rows[i].count; k++)
          send_rx(directed_rows[i].value,
                  directed_rows[i].stated && k == directed_rows[i].count - 1,
                  directed_rows[i].rec);
      end
    end

    for (int phase = 0; phase < RandomPhases; phase++) begin
      drain();
      mode = (phase < 5) ? phase : $urandom_range(0, 4);
      v = byte_t'($urandom_range(0, 255));
      case (mode)
        0: begin
          cfg_write(CFG_SYNC_FIRST, SyncFirstRst);
          cfg_write(CFG_SYNC_SECOND, SyncSecondRst);
        end
        1: begin
          cfg_write(CFG_SYNC_FIRST, byte_t'($urandom_range(0, 255)));
          cfg_write(CFG_SYNC_SECOND, byte_t'($urandom_range(0, 255)));
        end
        2: begin
          cfg_write(CFG_SYNC_FIRST, v);
          cfg_write(CFG_SYNC_SECOND, v);
        end
        3: begin
          cfg_write(CFG_SYNC_FIRST, 8'h00);
          cfg_write(CFG_SYNC_SECOND, 8'hFF);
        end
        default: begin
          cfg_write(CFG_SYNC_FIRST, 8'hFF);
          cfg_write(CFG_SYNC_SECOND, 8'h00);
        end
      endcase
      if ($urandom_range(0, 1) != 0)
        cfg_write($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                  byte_t'($urandom_range(0, 255)));
      src_gaps  = $urandom_range(0, 3) != 0;
      sink_gaps = $urandom_range(0, 3) != 0;

      counted = words_sent;
      while (words_sent - counted < PhaseWords) begin
        r = $urandom_range(0, 19);
        if (r == 0) begin
          drain();
        end else if (r < 15) begin
          repeat ($urandom_range(0, 2)) send_rx(byte_t'($urandom_range(0, 255)), 1'b0, '0);
          if ($urandom_range(0, 3) == 0) send_rx(want_first, 1'b0, '0);
          send_rx(want_first, 1'b0, '0);
          send_rx(want_second, 1'b0, '0);
          for (int k = 0; k < PayloadBytesDef; k++) begin
            if ($urandom_range(0, 7) == 0)
              pb = $urandom_range(0, 1) ? want_first : want_second;
            else
              pb = byte_t'($urandom_range(0, 255));
            send_rx(pb, 1'b0, '0);
          end
        end else if (r < 17) begin
          send_rx(want_first, 1'b0, '0);
          send_rx(byte_t'($urandom_range(0, 255)), 1'b0, '0);
        end else begin
          repeat ($urandom_range(1, 6)) send_rx(byte_t'($urandom_range(0, 255)), 1'b0, '0);
        end
      end
    end

    in_valid_i <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (miss_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sync_header_packet_deframer.f =====
hw/rtl/shpd_pkg.sv
hw/rtl/sync_header_packet_deframer.sv
test/sync_header_packet_deframer_test.sv
